>>> hdl/conditional_nesting_filter_defines.svh
// Assertion macros for the conditional nesting filter checker.
// No dependencies; included by the checker file only.
`ifndef CONDITIONAL_NESTING_FILTER_DEFINES_SVH
`define CONDITIONAL_NESTING_FILTER_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define CNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CNF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cnf_pkg.sv
// Package for the conditional nesting filter: payload structs, codes,
// the transition table and the action table. No dependencies.
package cnf_pkg;

  localparam int NUM_KINDS   = 10;
  localparam int NUM_STATES  = 10;
  localparam int NUM_ACTS    = 25;
  localparam int LINE_W      = 24;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    LK_IF, LK_IF_TRUE, LK_IF_FALSE, LK_ELIF, LK_ELIF_TRUE, LK_ELIF_FALSE,
    LK_ELSE, LK_ENDIF, LK_PLAIN, LK_EOF
  } line_kind_t;

  typedef enum logic [3:0] {
    S_OUTSIDE, S_FALSE_PREFIX, S_TRUE_PREFIX, S_PASS_MIDDLE, S_FALSE_MIDDLE,
    S_TRUE_MIDDLE, S_PASS_ELSE, S_FALSE_ELSE, S_TRUE_ELSE, S_FALSE_TRAILER
  } level_state_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_ORPHAN_ELIF, ERR_ORPHAN_ELSE, ERR_ORPHAN_ENDIF,
    ERR_EARLY_EOF, ERR_TOO_DEEP, ERR_HALTED
  } err_code_t;

  typedef enum logic [1:0] {RW_NONE, RW_IF, RW_ELSE, RW_ENDIF} rewrite_t;

  typedef enum logic [2:0] {K_STAY, K_SET, K_NEST, K_POP, K_ERR, K_EOF} act_kind_t;

  typedef enum logic [4:0] {
    A_PRINT, A_DROP, A_FPASS, A_FTRUE, A_FFALSE, A_FDROP, A_STRUE, A_SFALSE,
    A_SELSE, A_PELIF, A_PELSE, A_DFALSE, A_DELIF, A_DELSE, A_MPASS, A_MTRUE,
    A_MELIF, A_MELSE, A_PENDIF, A_DENDIF, A_OELIF, A_OELSE, A_OENDIF,
    A_EARLY, A_DONE
  } act_id_t;

  typedef struct packed {
    logic      keep;
    rewrite_t  rewrite;
    act_kind_t kind;
    logic [3:0] arg;   // new state, or error code
  } act_t;

  localparam act_t ACTS [NUM_ACTS] = '{
    '{1'b1, RW_NONE,  K_STAY, 4'd0}, '{1'b0, RW_NONE,  K_STAY, 4'd0},
    '{1'b1, RW_NONE,  K_NEST, 4'd3}, '{1'b0, RW_NONE,  K_NEST, 4'd2},
    '{1'b0, RW_NONE,  K_NEST, 4'd1}, '{1'b0, RW_NONE,  K_NEST, 4'd9},
    '{1'b0, RW_NONE,  K_SET,  4'd2}, '{1'b0, RW_NONE,  K_SET,  4'd1},
    '{1'b0, RW_NONE,  K_SET,  4'd8},
    '{1'b1, RW_NONE,  K_SET,  4'd3}, '{1'b1, RW_NONE,  K_SET,  4'd6},
    '{1'b0, RW_NONE,  K_SET,  4'd9}, '{1'b0, RW_NONE,  K_SET,  4'd4},
    '{1'b0, RW_NONE,  K_SET,  4'd7},
    '{1'b1, RW_IF,    K_SET,  4'd3}, '{1'b1, RW_ELSE,  K_SET,  4'd5},
    '{1'b1, RW_ENDIF, K_SET,  4'd9}, '{1'b1, RW_ENDIF, K_SET,  4'd7},
    '{1'b1, RW_NONE,  K_POP,  4'd0}, '{1'b0, RW_NONE,  K_POP,  4'd0},
    '{1'b0, RW_NONE,  K_ERR,  4'd1}, '{1'b0, RW_NONE,  K_ERR,  4'd2},
    '{1'b0, RW_NONE,  K_ERR,  4'd3}, '{1'b0, RW_NONE,  K_ERR,  4'd4},
    '{1'b0, RW_NONE,  K_EOF,  4'd0}
  };

  // Rows follow level_state_t, columns follow line_kind_t.
  localparam act_id_t TRANS [NUM_STATES][NUM_KINDS] = '{
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_OENDIF,
      A_PRINT, A_DONE},
    '{A_FDROP, A_FDROP, A_FDROP, A_MPASS, A_STRUE, A_SFALSE, A_SELSE, A_DENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_DFALSE, A_DFALSE, A_DFALSE, A_DELSE, A_DENDIF,
      A_PRINT, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_PELIF, A_MTRUE, A_DELIF, A_PELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_PELIF, A_MTRUE, A_DELIF, A_PELSE, A_PENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_MELIF, A_MELIF, A_MELIF, A_MELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_DENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_DENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_DFALSE, A_DFALSE, A_DFALSE, A_DELSE, A_DENDIF,
      A_DROP, A_EARLY}
  };

  typedef struct packed {
    logic [3:0]        line_kind;
    logic [LINE_W-1:0] line_number;
    logic              in_comment;
    logic              in_quote;
  } in_item_t;

  typedef struct packed {
    logic              keep_line;
    logic [1:0]        keyword_rewrite;
    logic [2:0]        error_code;
    logic              eof_in_comment;
    logic              eof_in_quote;
    logic [5:0]        nest_depth;
    logic [3:0]        level_state;
    logic              dropping;
    logic              unconditional;
    logic [LINE_W-1:0] open_start_line;
  } out_item_t;

  // Classified line as handed from the front to the back.
  typedef struct packed {
    logic              known;
    line_kind_t        kind;
    logic [LINE_W-1:0] line;
    logic              in_comment;
    logic              in_quote;
  } cmd_t;

  // One nesting level: its state and the line where its #if opened.
  typedef struct packed {
    level_state_t      state;
    logic [LINE_W-1:0] line;
  } level_t;

endpackage

>>> hdl/conditional_nesting_filter.sv
// Top level of the conditional nesting filter: front, queue and back.
// Depends on cnf_pkg, cnf_front, cnf_queue and cnf_back.
//
//   channel | ports                          | direction | payload
//   in      | in_valid, in_ready, in_data    | input     | in_item_t
//   out     | out_valid, out_ready, out_data | output    | out_item_t
//
// One line per cycle sustained while out_ready holds; each line loads the input
// register, then a queue slot, then the result register.
// The back end updates the top of the nesting stack in registers; one stack
// memory write on a nest and one prefetch read on a pop keep the back end
// from stalling between lines.
// Reset (rst_n, synchronous) clears depth, top level and halt; no clearing pass.
// A stalled output fills the queue, then the front register, then drops in_ready.
module conditional_nesting_filter
  import cnf_pkg::*;
#(
  parameter int MAX_NEST = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  cnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  cnf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  cnf_back #(
    .MAX_NEST (MAX_NEST)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cnf_front.sv
// Front end: registers incoming lines and classifies the line kind.
// Depends on cnf_pkg.
module cnf_front
  import cnf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic known;

  // Classify: codes past end of file are unknown and leave everything alone
  assign known = (in_data.line_kind < 4'(NUM_KINDS));

  always_comb begin
    cmd_nxt.known      = known;
    cmd_nxt.kind       = known ? line_kind_t'(in_data.line_kind) : LK_PLAIN;
    cmd_nxt.line       = in_data.line_number;
    cmd_nxt.in_comment = in_data.in_comment;
    cmd_nxt.in_quote   = in_data.in_quote;
  end

  // Take a new line whenever the held one moves on
  assign in_ready  = !valid_r || cmd_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

>>> hdl/cnf_queue.sv
// Short queue of classified lines between front and back.
// Depends on cnf_pkg (cmd_t, QUEUE_DEPTH).
module cnf_queue
  import cnf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != (PW+1)'(QUEUE_DEPTH)) || pop_ready;
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/cnf_back.sv
// Back end: nesting stack, transition lookup and result register.
// Depends on cnf_pkg (tables, level_t, out_item_t).
module cnf_back
  import cnf_pkg::*;
#(
  parameter int MAX_NEST = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DW = $clog2(MAX_NEST);
  localparam logic [DW-1:0] DEPTH_LAST = DW'(MAX_NEST - 1);

  // Levels below the top; the top level lives in registers
  level_t        mem [MAX_NEST];
  level_t        rd_r;
  level_t        below_r, below_nxt, below_eff;
  logic          sel_rd_r, sel_rd_nxt;

  level_state_t  top_state_r, top_state_nxt;
  logic [LINE_W-1:0] top_line_r, top_line_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          halted_r, halted_nxt;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          go, push, pop;
  logic [DW-1:0] rd_addr;
  act_t          act;

  assign cmd_ready = !out_valid_r || out_ready;
  assign go        = cmd_valid && cmd_ready;
  assign below_eff = sel_rd_r ? rd_r : below_r;
  assign rd_addr   = depth_r - DW'(2);
  assign act       = ACTS[TRANS[top_state_r][cmd.kind]];

  // Carry out the table action and build the result
  always_comb begin
    top_state_nxt = top_state_r;
    top_line_nxt  = top_line_r;
    depth_nxt     = depth_r;
    halted_nxt    = halted_r;
    below_nxt     = below_r;
    sel_rd_nxt    = sel_rd_r;
    push          = 1'b0;
    pop           = 1'b0;
    out_data_nxt  = '0;
    out_data_nxt.error_code = ERR_NONE;

    if (go) begin
      if (halted_r) begin
        out_data_nxt.error_code = ERR_HALTED;
      end else if (cmd.known) begin
        unique case (act.kind)
          K_STAY: begin
            out_data_nxt.keep_line = act.keep;
          end
          K_SET: begin
            top_state_nxt                = level_state_t'(act.arg);
            out_data_nxt.keep_line       = act.keep;
            out_data_nxt.keyword_rewrite = act.rewrite;
          end
          K_NEST: begin
            if (depth_r == DEPTH_LAST) begin
              out_data_nxt.error_code = ERR_TOO_DEEP;
              halted_nxt              = 1'b1;
            end else begin
              push                   = 1'b1;
              below_nxt              = '{state: top_state_r, line: top_line_r};
              sel_rd_nxt             = 1'b0;
              depth_nxt              = depth_r + 1'b1;
              top_state_nxt          = level_state_t'(act.arg);
              top_line_nxt           = cmd.line;
              out_data_nxt.keep_line = act.keep;
            end
          end
          K_POP: begin
            if (depth_r != '0) begin
              pop           = 1'b1;
              sel_rd_nxt    = 1'b1;
              depth_nxt     = depth_r - 1'b1;
              top_state_nxt = below_eff.state;
              top_line_nxt  = below_eff.line;
            end
            out_data_nxt.keep_line = act.keep;
          end
          K_ERR: begin
            out_data_nxt.error_code = act.arg[2:0];
            halted_nxt              = 1'b1;
          end
          K_EOF: begin
            out_data_nxt.eof_in_comment = cmd.in_comment;
            out_data_nxt.eof_in_quote   = cmd.in_quote;
          end
          default: begin
            out_data_nxt.keep_line = 1'b0;
          end
        endcase
      end
    end

    out_data_nxt.nest_depth      = 6'(depth_nxt);
    out_data_nxt.level_state     = top_state_nxt;
    out_data_nxt.open_start_line = top_line_nxt;
    case (top_state_nxt) inside
      S_FALSE_PREFIX, S_FALSE_MIDDLE, S_FALSE_ELSE, S_FALSE_TRAILER:
        out_data_nxt.dropping = 1'b1;
      default:
        out_data_nxt.dropping = 1'b0;
    endcase
    case (top_state_nxt) inside
      S_OUTSIDE, S_TRUE_PREFIX, S_TRUE_MIDDLE, S_TRUE_ELSE:
        out_data_nxt.unconditional = 1'b1;
      default:
        out_data_nxt.unconditional = 1'b0;
    endcase

    // Hold the result until taken, load a new one on every accepted line
    out_valid_nxt = go ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_state_r <= S_OUTSIDE;
      top_line_r  <= '0;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      sel_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      top_state_r <= top_state_nxt;
      top_line_r  <= top_line_nxt;
      depth_r     <= depth_nxt;
      halted_r    <= halted_nxt;
      sel_rd_r    <= sel_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    below_r <= below_nxt;
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Stack memory: push writes the old top, pop prefetches the next level down
  always_ff @(posedge clk) begin
    if (push) begin
      mem[depth_r] <= '{state: top_state_r, line: top_line_r};
    end
    if (pop) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/cnf_checker.sv
// Port-level checker for the conditional nesting filter, bound to the top.
// Depends on cnf_pkg and conditional_nesting_filter_defines.svh.
`include "conditional_nesting_filter_defines.svh"

module cnf_checker
  import cnf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_stall, out_stall, out_err, err_xfer, out_halted, out_clean;
  assign in_stall   = in_valid && !in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign out_err    = out_valid && (out_data.error_code != ERR_NONE);
  assign err_xfer   = out_err && out_ready;
  assign out_halted = (out_data.error_code == ERR_HALTED);
  assign out_clean  = !out_data.keep_line && (out_data.keyword_rewrite == RW_NONE) &&
                      !out_data.eof_in_comment;

  // No result shows in the cycle after reset
  `CNF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

  // Hold a stalled result
  `CNF_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // Hold a stalled line at the input
  `CNF_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(in_data), "line changed while stalled")

  // After any error transfer, a result shown straight after it reports the halt
  `CNF_ASSERT(a_halt_sticky, err_xfer |=> !out_valid || out_halted, "result after an error not halted")

  // Drop the line and leave the keyword alone on any error
  `CNF_ASSERT(a_err_drop, out_err |-> out_clean, "kept or rewrote a line in error")

endmodule

bind conditional_nesting_filter cnf_checker u_cnf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/conditional_nesting_filter_tb.sv
// Testbench for conditional_nesting_filter: directed and random line streams,
// checked against a line-by-line prediction of the nesting state machine.
// Depends on cnf_pkg and the conditional_nesting_filter RTL.
`timescale 1ns / 1ps

module conditional_nesting_filter_tb;
  import cnf_pkg::*;

  localparam int NEST_LIMIT  = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;
  localparam int RANDOM_RUN  = 90;

  // One table action: keep flag, keyword rewrite, stack effect, new state or error.
  typedef struct packed {
    logic      keep;
    rewrite_t  rw;
    act_kind_t effect;
    logic [3:0] arg;
  } line_action_t;

  localparam line_action_t ACTION_OF [NUM_ACTS] = '{
    '{1'b1, RW_NONE,  K_STAY, 4'(S_OUTSIDE)},       // print
    '{1'b0, RW_NONE,  K_STAY, 4'(S_OUTSIDE)},       // drop
    '{1'b1, RW_NONE,  K_NEST, 4'(S_PASS_MIDDLE)},   // open, pass through
    '{1'b0, RW_NONE,  K_NEST, 4'(S_TRUE_PREFIX)},   // open, resolved true
    '{1'b0, RW_NONE,  K_NEST, 4'(S_FALSE_PREFIX)},  // open, resolved false
    '{1'b0, RW_NONE,  K_NEST, 4'(S_FALSE_TRAILER)}, // open inside dropped text
    '{1'b0, RW_NONE,  K_SET,  4'(S_TRUE_PREFIX)},
    '{1'b0, RW_NONE,  K_SET,  4'(S_FALSE_PREFIX)},
    '{1'b0, RW_NONE,  K_SET,  4'(S_TRUE_ELSE)},
    '{1'b1, RW_NONE,  K_SET,  4'(S_PASS_MIDDLE)},
    '{1'b1, RW_NONE,  K_SET,  4'(S_PASS_ELSE)},
    '{1'b0, RW_NONE,  K_SET,  4'(S_FALSE_TRAILER)},
    '{1'b0, RW_NONE,  K_SET,  4'(S_FALSE_MIDDLE)},
    '{1'b0, RW_NONE,  K_SET,  4'(S_FALSE_ELSE)},
    '{1'b1, RW_IF,    K_SET,  4'(S_PASS_MIDDLE)},
    '{1'b1, RW_ELSE,  K_SET,  4'(S_TRUE_MIDDLE)},
    '{1'b1, RW_ENDIF, K_SET,  4'(S_FALSE_TRAILER)},
    '{1'b1, RW_ENDIF, K_SET,  4'(S_FALSE_ELSE)},
    '{1'b1, RW_NONE,  K_POP,  4'(S_OUTSIDE)},
    '{1'b0, RW_NONE,  K_POP,  4'(S_OUTSIDE)},
    '{1'b0, RW_NONE,  K_ERR,  4'(ERR_ORPHAN_ELIF)},
    '{1'b0, RW_NONE,  K_ERR,  4'(ERR_ORPHAN_ELSE)},
    '{1'b0, RW_NONE,  K_ERR,  4'(ERR_ORPHAN_ENDIF)},
    '{1'b0, RW_NONE,  K_ERR,  4'(ERR_EARLY_EOF)},
    '{1'b0, RW_NONE,  K_EOF,  4'(S_OUTSIDE)}
  };

  // Rows: level state. Columns: line kind.
  localparam act_id_t NEXT_ACTION [NUM_STATES][NUM_KINDS] = '{
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_OENDIF,
      A_PRINT, A_DONE},
    '{A_FDROP, A_FDROP, A_FDROP, A_MPASS, A_STRUE, A_SFALSE, A_SELSE, A_DENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_DFALSE, A_DFALSE, A_DFALSE, A_DELSE, A_DENDIF,
      A_PRINT, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_PELIF, A_MTRUE, A_DELIF, A_PELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_PELIF, A_MTRUE, A_DELIF, A_PELSE, A_PENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_MELIF, A_MELIF, A_MELIF, A_MELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_PENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_DENDIF,
      A_DROP, A_EARLY},
    '{A_FPASS, A_FTRUE, A_FFALSE, A_OELIF, A_OELIF, A_OELIF, A_OELSE, A_DENDIF,
      A_PRINT, A_EARLY},
    '{A_FDROP, A_FDROP, A_FDROP, A_DFALSE, A_DFALSE, A_DFALSE, A_DELSE, A_DENDIF,
      A_DROP, A_EARLY}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Predicted nesting state
  level_state_t lvl_state [NEST_LIMIT];
  logic [LINE_W-1:0] lvl_start [NEST_LIMIT];
  int lvl = 0;
  bit halt_seen = 1'b0;

  // Predicted verdicts for accepted lines, oldest first
  out_item_t line_verdicts_q [$];

  conditional_nesting_filter #(.MAX_NEST(NEST_LIMIT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Apply one line to the predicted state and return the expected verdict.
  function automatic out_item_t predict_verdict(in_item_t ln);
    out_item_t v;
    line_action_t act;
    level_state_t cur;
    v = '0;
    if (halt_seen) begin
      v.error_code = ERR_HALTED;
    end else if (ln.line_kind < NUM_KINDS) begin
      act = ACTION_OF[NEXT_ACTION[lvl_state[lvl]][ln.line_kind]];
      case (act.effect)
        K_SET: begin
          lvl_state[lvl] = level_state_t'(act.arg);
          v.keep_line = act.keep;
          v.keyword_rewrite = act.rw;
        end
        K_NEST: begin
          if (lvl + 1 >= NEST_LIMIT) begin
            v.error_code = ERR_TOO_DEEP;
            halt_seen = 1'b1;
          end else begin
            lvl++;
            lvl_start[lvl] = ln.line_number;
            lvl_state[lvl] = level_state_t'(act.arg);
            v.keep_line = act.keep;
          end
        end
        K_POP: begin
          if (lvl > 0) lvl--;
          v.keep_line = act.keep;
        end
        K_ERR: begin
          v.error_code = act.arg[2:0];
          halt_seen = 1'b1;
        end
        K_EOF: begin
          v.eof_in_comment = ln.in_comment;
          v.eof_in_quote = ln.in_quote;
        end
        default: v.keep_line = act.keep;
      endcase
    end
    cur = lvl_state[lvl];
    v.nest_depth = lvl[5:0];
    v.level_state = cur;
    v.dropping = (cur == S_FALSE_PREFIX) || (cur == S_FALSE_MIDDLE) ||
                 (cur == S_FALSE_ELSE) || (cur == S_FALSE_TRAILER);
    v.unconditional = (cur == S_OUTSIDE) || (cur == S_TRUE_PREFIX) ||
                      (cur == S_TRUE_MIDDLE) || (cur == S_TRUE_ELSE);
    v.open_start_line = (lvl == 0) ? '0 : lvl_start[lvl];
    return v;
  endfunction

  // True when the kind cannot stop the block in the current predicted state.
  function automatic bit kind_is_safe(logic [3:0] k);
    level_state_t cur;
    cur = lvl_state[lvl];
    if (k >= NUM_KINDS) return 1'b1;
    case (line_kind_t'(k))
      LK_IF, LK_IF_TRUE, LK_IF_FALSE: return lvl + 1 < NEST_LIMIT;
      LK_ELIF, LK_ELIF_TRUE, LK_ELIF_FALSE, LK_ELSE:
        return lvl > 0 && cur != S_PASS_ELSE && cur != S_FALSE_ELSE && cur != S_TRUE_ELSE;
      LK_ENDIF: return lvl > 0;
      LK_PLAIN: return 1'b1;
      default:  return lvl == 0;
    endcase
  endfunction

  function automatic in_item_t line_of(logic [3:0] k, logic [LINE_W-1:0] num,
                                       logic c, logic q);
    in_item_t ln;
    ln.line_kind = k;
    ln.line_number = num;
    ln.in_comment = c;
    ln.in_quote = q;
    return ln;
  endfunction

  function automatic in_item_t make_line(logic [3:0] k);
    logic [LINE_W-1:0] num;
    case ($urandom_range(9))
      0: num = '0;
      1: num = '1;
      default: num = LINE_W'($urandom);
    endcase
    return line_of(k, num, 1'($urandom), 1'($urandom));
  endfunction

  // Pick a kind that keeps the block running, biased toward balanced nesting.
  function automatic logic [3:0] pick_safe_kind();
    logic [3:0] k;
    int r;
    do begin
      r = $urandom_range(99);
      if (r < 3)       k = 4'(NUM_KINDS + $urandom_range(5));
      else if (r < 25) k = 4'($urandom_range(2));
      else if (r < 45) k = LK_ENDIF;
      else if (r < 62) k = 4'(LK_ELIF + $urandom_range(2));
      else if (r < 72) k = LK_ELSE;
      else if (r < 95) k = LK_PLAIN;
      else             k = LK_EOF;
    end while (!kind_is_safe(k));
    return k;
  endfunction

  // Drive one line, hold it until the transfer, then record its verdict.
  task automatic send_line(in_item_t ln);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= ln;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_verdicts_q.push_back(predict_verdict(ln));
  endtask

  task automatic send_kind(logic [3:0] k);
    send_line(make_line(k));
  endtask

  // Idle the sender and wait until every accepted line has its result
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_verdicts_q.size() != 0) @(posedge clk);
  endtask

  // Send n lines that the block acts on, plus any ignored noise lines.
  task automatic send_random_lines(int n);
    int sent;
    logic [3:0] k;
    sent = 0;
    while (sent < n) begin
      k = pick_safe_kind();
      send_kind(k);
      if (k < NUM_KINDS) sent++;
    end
  endtask

  task automatic close_all_levels();
    while (lvl > 0) send_kind(LK_ENDIF);
  endtask

  // Compare one result field
  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $error("%s: expected %0h, actual %0h", name, exp, got);
      fail_count++;
    end
  endtask

  // Check each result transfer against the oldest verdict
  always @(posedge clk) begin : check_results
    out_item_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (line_verdicts_q.size() == 0) begin
        $error("result transfer with no line outstanding");
        fail_count++;
      end else begin
        exp = line_verdicts_q.pop_front();
        check_field("keep_line", 32'(exp.keep_line), 32'(out_data.keep_line));
        check_field("keyword_rewrite", 32'(exp.keyword_rewrite),
                    32'(out_data.keyword_rewrite));
        check_field("error_code", 32'(exp.error_code), 32'(out_data.error_code));
        check_field("eof_in_comment", 32'(exp.eof_in_comment),
                    32'(out_data.eof_in_comment));
        check_field("eof_in_quote", 32'(exp.eof_in_quote), 32'(out_data.eof_in_quote));
        check_field("nest_depth", 32'(exp.nest_depth), 32'(out_data.nest_depth));
        check_field("level_state", 32'(exp.level_state), 32'(out_data.level_state));
        check_field("dropping", 32'(exp.dropping), 32'(out_data.dropping));
        check_field("unconditional", 32'(exp.unconditional),
                    32'(out_data.unconditional));
        check_field("open_start_line", 32'(exp.open_start_line),
                    32'(out_data.open_start_line));
      end
    end
  end

  // Top-level eof flags, ignored kinds and each branch shape of a block
  task automatic test_directed_lines();
    gap_pct = 0;
    stall_pct = 0;
    send_line(line_of(LK_PLAIN, '0, 1'b0, 1'b0));
    send_line(line_of(LK_EOF, '1, 1'b1, 1'b0));
    send_line(line_of(LK_EOF, 24'd1, 1'b0, 1'b1));
    send_line(line_of(LK_EOF, 24'd2, 1'b1, 1'b1));
    send_line(line_of(4'hF, '1, 1'b1, 1'b1));
    // true prefix, then everything after it dropped
    send_line(line_of(LK_IF_TRUE, '1, 1'b0, 1'b0));
    send_line(line_of(LK_ELIF, 24'd10, 1'b0, 1'b0));
    send_line(line_of(LK_PLAIN, 24'd11, 1'b1, 1'b1));
    send_line(line_of(LK_ELSE, 24'd12, 1'b0, 1'b0));
    send_line(line_of(LK_ENDIF, 24'd13, 1'b0, 1'b0));
    // pass-through block whose middle resolves true
    send_line(line_of(LK_IF, 24'h123456, 1'b0, 1'b0));
    send_line(line_of(LK_ELIF_TRUE, 24'd21, 1'b0, 1'b0));
    send_line(line_of(LK_ELSE, 24'd22, 1'b0, 1'b0));
    send_line(line_of(LK_ENDIF, 24'd23, 1'b0, 1'b0));
    // false prefix rewritten to if, then a nested pass-through block
    send_line(line_of(LK_IF_FALSE, 24'd30, 1'b0, 1'b0));
    send_line(line_of(LK_ELIF, 24'd31, 1'b0, 1'b0));
    send_line(line_of(LK_ELIF_FALSE, 24'd32, 1'b0, 1'b0));
    send_line(line_of(LK_ELSE, 24'd33, 1'b0, 1'b0));
    send_line(line_of(LK_IF, 24'd34, 1'b0, 1'b0));
    send_line(line_of(LK_ENDIF, 24'd35, 1'b0, 1'b0));
    send_line(line_of(LK_ENDIF, 24'd36, 1'b0, 1'b0));
    // false prefix, false elif, true else
    send_line(line_of(LK_IF_FALSE, 24'd40, 1'b0, 1'b0));
    send_line(line_of(LK_ELIF_FALSE, 24'd41, 1'b0, 1'b0));
    send_line(line_of(LK_ELSE, 24'd42, 1'b0, 1'b0));
    send_line(line_of(LK_ENDIF, 24'd43, 1'b0, 1'b0));
    send_line(line_of(4'hA, 24'd44, 1'b0, 1'b0));
  endtask

  // Open levels up to the deepest allowed, then close them all
  task automatic test_deep_nesting();
    gap_pct = 0;
    stall_pct = 0;
    while (lvl + 1 < NEST_LIMIT) send_kind(4'($urandom_range(2)));
    send_kind(LK_PLAIN);
    close_all_levels();
  endtask

  task automatic test_random_back_to_back();
    gap_pct = 0;
    stall_pct = 0;
    send_random_lines(RANDOM_RUN);
  endtask

  task automatic test_random_sender_gaps();
    gap_pct = 65;
    stall_pct = 0;
    send_random_lines(RANDOM_RUN);
  endtask

  task automatic test_random_receiver_stalls();
    gap_pct = 0;
    stall_pct = 65;
    send_random_lines(RANDOM_RUN);
  endtask

  task automatic test_random_both();
    gap_pct = 19;
    stall_pct = 19;
    send_random_lines(RANDOM_RUN);
  endtask

  // Raise one structural error, chosen at random, then confirm the halt holds
  task automatic test_fatal_error();
    int pick;
    gap_pct = 19;
    stall_pct = 19;
    close_all_levels();
    pick = $urandom_range(4);
    case (pick)
      0, 1: begin
        // orphan elif or else: at top level, or after an else
        if ($urandom_range(1)) begin
          send_kind(4'($urandom_range(2)));
          send_kind(LK_ELSE);
        end
        if (pick == 0) send_kind(4'(LK_ELIF + $urandom_range(2)));
        else send_kind(LK_ELSE);
      end
      2: send_kind(LK_ENDIF);
      3: begin
        // end of file inside an open block
        repeat ($urandom_range(1, 3)) send_kind(4'($urandom_range(2)));
        send_kind(LK_EOF);
      end
      default: begin
        while (lvl + 1 < NEST_LIMIT) send_kind(4'($urandom_range(2)));
        send_kind(4'($urandom_range(2)));
      end
    endcase
    repeat (10) send_kind(4'($urandom_range(15)));
  endtask

  initial begin
    for (int i = 0; i < NEST_LIMIT; i++) begin
      lvl_state[i] = S_OUTSIDE;
      lvl_start[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_deep_nesting();
    test_random_back_to_back();
    // hold off until the block has emptied
    wait_for_verdicts();
    test_random_sender_gaps();
    wait_for_verdicts();
    test_random_receiver_stalls();
    test_random_both();
    wait_for_verdicts();
    test_fatal_error();

    wait_for_verdicts();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (line_verdicts_q.size() != 0) begin
      $error("%0d lines without a result", line_verdicts_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
